/* rtl/core/dmsef_pkg.sv */
// ----------------------------------------------------------------------------
// dmsef_pkg
// Shared types and constants for the distance median / spike-skip /
// exponential filter chain.
// ----------------------------------------------------------------------------
package dmsef_pkg;

  localparam int unsigned DEF_DIST_WIDTH = 10;

  localparam int unsigned THR_W      = 10;
  localparam int unsigned WIN_W      = 8;
  localparam int unsigned CFG_DATA_W = 10;
  localparam int unsigned CFG_IDX_W  = 1;

  localparam int unsigned EXP_SHIFT  = 4;   // 16x resolution
  localparam int unsigned RING_DEPTH = 3;
  localparam int unsigned SLOT_W     = 2;

  localparam logic [THR_W-1:0] JUMP_THRESHOLD_RST = THR_W'(80);
  localparam logic [WIN_W-1:0] HOLD_WINDOW_RST    = WIN_W'(7);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_JUMP_THRESHOLD = 1'b0,
    CFG_HOLD_WINDOW    = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [THR_W-1:0] jump_threshold;
    logic [WIN_W-1:0] hold_window;
  } spike_cfg_t;

  typedef struct packed {
    logic advance;
    logic valid;
  } stage_ctl_t;

endpackage

/* rtl/core/distance_median_skip_exp_filter.sv */
// ----------------------------------------------------------------------------
// distance_median_skip_exp_filter
// Median-of-three, spike-skip and exponential filter chain for distance words.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid_i/in_ready_o carries one distance word in mm
//   (0 = no echo). Output channel out_valid_o/out_ready_i returns one word
//   per input with the median, the spike-rejected and the smoothed distance.
//   Configuration writes (cfg_we_i, cfg_idx_i, cfg_wdata_i) take effect at
//   the clock edge; write only while the chain is empty.
//   An accepted word passes the median, spike-skip and smoothing registers
//   before output valid. Throughput: one word per cycle while the receiver
//   does not stall.
//   Reset clears the ring, held value, suspect count and accumulator and
//   loads jump_threshold = 80, hold_window = 7.
//   When the receiver stalls, the whole chain holds and in_ready_o drops
//   while the output word waits; up to three words are held in flight.
// ----------------------------------------------------------------------------
module distance_median_skip_exp_filter #(
  parameter int unsigned DIST_WIDTH = dmsef_pkg::DEF_DIST_WIDTH
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [dmsef_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [dmsef_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [DIST_WIDTH-1:0]              distance_mm_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [DIST_WIDTH-1:0]              median_mm_o,
  output logic [DIST_WIDTH-1:0]              held_mm_o,
  output logic [DIST_WIDTH-1:0]              smooth_mm_o
);
  import dmsef_pkg::*;

  spike_cfg_t            cfg_q;
  logic                  advance;
  stage_ctl_t            med_ctl, spk_ctl, exp_ctl;
  logic                  med_valid, spk_valid;
  logic [DIST_WIDTH-1:0] med_mm, spk_med_mm, spk_held_mm;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.jump_threshold <= JUMP_THRESHOLD_RST;
      cfg_q.hold_window    <= HOLD_WINDOW_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_JUMP_THRESHOLD: cfg_q.jump_threshold <= cfg_wdata_i[THR_W-1:0];
        CFG_HOLD_WINDOW:    cfg_q.hold_window    <= cfg_wdata_i[WIN_W-1:0];
        default: ;
      endcase
    end
  end

  assign advance    = !out_valid_o || out_ready_i;
  assign in_ready_o = advance;

  assign med_ctl = '{advance: advance, valid: in_valid_i};
  assign spk_ctl = '{advance: advance, valid: med_valid};
  assign exp_ctl = '{advance: advance, valid: spk_valid};

  dmsef_median3 #(
    .DIST_WIDTH(DIST_WIDTH)
  ) u_median (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (med_ctl),
    .sample_i (distance_mm_i),
    .valid_o  (med_valid),
    .median_o (med_mm)
  );

  dmsef_spike_skip #(
    .DIST_WIDTH(DIST_WIDTH)
  ) u_spike (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (spk_ctl),
    .cfg_i    (cfg_q),
    .median_i (med_mm),
    .valid_o  (spk_valid),
    .median_o (spk_med_mm),
    .held_o   (spk_held_mm)
  );

  dmsef_exp_smooth #(
    .DIST_WIDTH(DIST_WIDTH)
  ) u_smooth (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (exp_ctl),
    .median_i (spk_med_mm),
    .held_i   (spk_held_mm),
    .valid_o  (out_valid_o),
    .median_o (median_mm_o),
    .held_o   (held_mm_o),
    .smooth_o (smooth_mm_o)
  );

  accept_fills_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> med_valid)
    else $error("accepted word did not enter median stage");

  stall_holds_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(med_valid) && $stable(spk_valid))
    else $error("pipeline moved while output stalled");

  zero_held_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && held_mm_o == '0 |-> smooth_mm_o == '0)
    else $error("smoothed value nonzero after zero held value");

  drain_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    spk_valid && advance |=> out_valid_o)
    else $error("spike stage word lost");

endmodule

/* rtl/core/dmsef_median3.sv */
// ----------------------------------------------------------------------------
// dmsef_median3
// Three-entry sample ring and registered median of the ring contents.
// ----------------------------------------------------------------------------
module dmsef_median3 #(
  parameter int unsigned DIST_WIDTH = dmsef_pkg::DEF_DIST_WIDTH
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  dmsef_pkg::stage_ctl_t   ctl_i,
  input  logic [DIST_WIDTH-1:0]   sample_i,
  output logic                    valid_o,
  output logic [DIST_WIDTH-1:0]   median_o
);
  import dmsef_pkg::*;

  logic [DIST_WIDTH-1:0] ring_q [RING_DEPTH];
  logic [SLOT_W-1:0]     slot_q, slot_d;
  logic [DIST_WIDTH-1:0] a, b, c, lo_ab, hi_ab, lo_hc, med_d;
  logic                  valid_q;
  logic [DIST_WIDTH-1:0] median_q;
  logic                  take;

  assign take = ctl_i.advance && ctl_i.valid;

  always_comb begin
    a = (slot_q == SLOT_W'(0)) ? sample_i : ring_q[0];
    b = (slot_q == SLOT_W'(1)) ? sample_i : ring_q[1];
    c = (slot_q == SLOT_W'(2)) ? sample_i : ring_q[2];
    lo_ab = (a < b) ? a : b;
    hi_ab = (a > b) ? a : b;
    lo_hc = (hi_ab < c) ? hi_ab : c;
    med_d = (lo_ab > lo_hc) ? lo_ab : lo_hc;
    slot_d = (slot_q == SLOT_W'(RING_DEPTH - 1)) ? '0 : slot_q + SLOT_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < RING_DEPTH; i++) ring_q[i] <= '0;
      slot_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      if (ctl_i.advance) valid_q <= ctl_i.valid;
      if (take) begin
        ring_q[0] <= a;
        ring_q[1] <= b;
        ring_q[2] <= c;
        slot_q    <= slot_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) median_q <= med_d;
  end

  assign valid_o  = valid_q;
  assign median_o = median_q;

  slot_range_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot_q != SLOT_W'(3))
    else $error("ring slot out of range");

endmodule

/* rtl/core/dmsef_spike_skip.sv */
// ----------------------------------------------------------------------------
// dmsef_spike_skip
// Replaces zero samples and large jumps by the held value until the run of
// suspect samples exceeds the hold window.
// ----------------------------------------------------------------------------
module dmsef_spike_skip #(
  parameter int unsigned DIST_WIDTH = dmsef_pkg::DEF_DIST_WIDTH
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  dmsef_pkg::stage_ctl_t   ctl_i,
  input  dmsef_pkg::spike_cfg_t   cfg_i,
  input  logic [DIST_WIDTH-1:0]   median_i,
  output logic                    valid_o,
  output logic [DIST_WIDTH-1:0]   median_o,
  output logic [DIST_WIDTH-1:0]   held_o
);
  import dmsef_pkg::*;

  localparam int unsigned CMP_W = (DIST_WIDTH > THR_W) ? DIST_WIDTH : THR_W;

  logic [DIST_WIDTH-1:0] held_q, held_d, prev;
  logic [WIN_W-1:0]      cnt_q, cnt_d, cnt_inc;
  logic [DIST_WIDTH-1:0] diff;
  logic                  suspect;
  logic                  valid_q;
  logic [DIST_WIDTH-1:0] median_q, out_q;
  logic                  take;

  assign take = ctl_i.advance && ctl_i.valid;

  always_comb begin
    prev = (held_q == '0 && median_i != '0) ? median_i : held_q;
    diff = (prev > median_i) ? prev - median_i : median_i - prev;
    suspect = (CMP_W'(diff) > CMP_W'(cfg_i.jump_threshold)) || (median_i == '0);
    cnt_inc = cnt_q + WIN_W'(1);
    held_d  = median_i;
    cnt_d   = '0;
    if (suspect) begin
      if (cnt_inc > cfg_i.hold_window) begin
        cnt_d = '0;
      end else begin
        cnt_d  = cnt_inc;
        held_d = prev;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q  <= '0;
      cnt_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (ctl_i.advance) valid_q <= ctl_i.valid;
      if (take) begin
        held_q <= held_d;
        cnt_q  <= cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      median_q <= median_i;
      out_q    <= held_d;
    end
  end

  assign valid_o  = valid_q;
  assign median_o = median_q;
  assign held_o   = out_q;

endmodule

/* rtl/core/dmsef_exp_smooth.sv */
// ----------------------------------------------------------------------------
// dmsef_exp_smooth
// Exponential filter at 16x resolution, divisor 2, cleared on a zero value.
// Holds the result word for the output channel.
// ----------------------------------------------------------------------------
module dmsef_exp_smooth #(
  parameter int unsigned DIST_WIDTH = dmsef_pkg::DEF_DIST_WIDTH
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  dmsef_pkg::stage_ctl_t   ctl_i,
  input  logic [DIST_WIDTH-1:0]   median_i,
  input  logic [DIST_WIDTH-1:0]   held_i,
  output logic                    valid_o,
  output logic [DIST_WIDTH-1:0]   median_o,
  output logic [DIST_WIDTH-1:0]   held_o,
  output logic [DIST_WIDTH-1:0]   smooth_o
);
  import dmsef_pkg::*;

  localparam int unsigned ACC_W = DIST_WIDTH + EXP_SHIFT;
  localparam int unsigned DIF_W = ACC_W + 1;

  logic [ACC_W-1:0]        acc_q, acc_d;
  logic signed [DIF_W-1:0] dif, step;
  logic                    valid_q;
  logic [DIST_WIDTH-1:0]   median_q, held_q, smooth_q;
  logic                    take;

  assign take = ctl_i.advance && ctl_i.valid;

  always_comb begin
    dif  = $signed({1'b0, held_i, EXP_SHIFT'(0)}) - $signed({1'b0, acc_q});
    // halve, rounding toward zero
    step = (dif + $signed({{(DIF_W-1){1'b0}}, dif[DIF_W-1]})) >>> 1;
    if (held_i == '0) begin
      acc_d = '0;
    end else begin
      acc_d = acc_q + step[ACC_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (ctl_i.advance) valid_q <= ctl_i.valid;
      if (take) acc_q <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      median_q <= median_i;
      held_q   <= held_i;
      smooth_q <= acc_d[ACC_W-1:EXP_SHIFT];
    end
  end

  assign valid_o  = valid_q;
  assign median_o = median_q;
  assign held_o   = held_q;
  assign smooth_o = smooth_q;

endmodule

/* tb/dmsef_filter_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmsef_filter_checker
// Watches the input, output and register ports of the distance filter chain,
// runs its own median / spike-skip / exponential model on every accepted
// input word and compares each output word, field by field, in order.
// ----------------------------------------------------------------------------
module dmsef_filter_checker #(
  parameter int unsigned DW = dmsef_pkg::DEF_DIST_WIDTH
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [dmsef_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [dmsef_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                             in_valid_i,
  input  logic                             in_ready_i,
  input  logic [DW-1:0]                    distance_mm_i,
  input  logic                             out_valid_i,
  input  logic                             out_ready_i,
  input  logic [DW-1:0]                    median_mm_i,
  input  logic [DW-1:0]                    held_mm_i,
  input  logic [DW-1:0]                    smooth_mm_i,
  output int                               fail_count_o,
  output int                               words_pending_o
);
  import dmsef_pkg::*;

  localparam int EXP_MULT    = 1 << EXP_SHIFT;
  localparam int EXP_DIV     = 2;
  localparam int MAX_REPORTS = 40;

  typedef struct packed {
    logic [DW-1:0] median_mm;
    logic [DW-1:0] held_mm;
    logic [DW-1:0] smooth_mm;
  } filter_word_t;

  filter_word_t expected_q[$];

  logic [THR_W-1:0] jump_thr;
  logic [WIN_W-1:0] hold_win;
  logic [DW-1:0]    ring_mm [RING_DEPTH];
  int unsigned      ring_pos;
  logic [DW-1:0]    held_prev_mm;
  logic [WIN_W-1:0] suspect_run;
  int               smooth_acc;

  initial fail_count_o = 0;

  task automatic report_mismatch(input string msg);
    if (fail_count_o < MAX_REPORTS) $display("[%0t] MISMATCH: %s", $time, msg);
    fail_count_o++;
  endtask

  function automatic filter_word_t filter_sample(input logic [DW-1:0] sample);
    filter_word_t res;
    logic [DW-1:0] lo, hi, med, val, diff;
    ring_mm[ring_pos] = sample;
    ring_pos = (ring_pos + 1 >= RING_DEPTH) ? 0 : ring_pos + 1;
    lo  = (ring_mm[0] < ring_mm[1]) ? ring_mm[0] : ring_mm[1];
    hi  = (ring_mm[0] > ring_mm[1]) ? ring_mm[0] : ring_mm[1];
    med = (hi < ring_mm[2]) ? hi : ring_mm[2];
    med = (lo > med) ? lo : med;

    val = med;
    if (held_prev_mm == '0 && val != '0) held_prev_mm = val;
    diff = (held_prev_mm > val) ? held_prev_mm - val : val - held_prev_mm;
    if (diff > jump_thr || val == '0) begin
      suspect_run = suspect_run + 1'b1;
      if (suspect_run > hold_win) suspect_run = '0;
      else val = held_prev_mm;
    end else begin
      suspect_run = '0;
    end
    held_prev_mm = val;

    if (val != '0) smooth_acc = smooth_acc + (int'(val) * EXP_MULT - smooth_acc) / EXP_DIV;
    else smooth_acc = 0;

    res.median_mm = med;
    res.held_mm   = val;
    res.smooth_mm = DW'(smooth_acc / EXP_MULT);
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    filter_word_t exp_w;
    if (!rst_ni) begin
      jump_thr     = JUMP_THRESHOLD_RST;
      hold_win     = HOLD_WINDOW_RST;
      ring_mm      = '{default: '0};
      ring_pos     = 0;
      held_prev_mm = '0;
      suspect_run  = '0;
      smooth_acc   = 0;
      expected_q.delete();
      words_pending_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          CFG_JUMP_THRESHOLD: jump_thr = cfg_wdata_i[THR_W-1:0];
          CFG_HOLD_WINDOW:    hold_win = cfg_wdata_i[WIN_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) expected_q.push_back(filter_sample(distance_mm_i));
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          report_mismatch($sformatf("output word with none expected (med %0d held %0d sm %0d)",
                                    median_mm_i, held_mm_i, smooth_mm_i));
        end else begin
          exp_w = expected_q.pop_front();
          if (median_mm_i !== exp_w.median_mm)
            report_mismatch($sformatf("median_mm got %0d exp %0d", median_mm_i, exp_w.median_mm));
          if (held_mm_i !== exp_w.held_mm)
            report_mismatch($sformatf("held_mm got %0d exp %0d", held_mm_i, exp_w.held_mm));
          if (smooth_mm_i !== exp_w.smooth_mm)
            report_mismatch($sformatf("smooth_mm got %0d exp %0d", smooth_mm_i, exp_w.smooth_mm));
        end
      end
      words_pending_o = expected_q.size();
    end
  end

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the distance filter chain: directed start-up, dropout,
// target-reappear and spike words, then random-walk distance traces with
// spikes and dropouts under many threshold / window settings, including a
// suspect-counter wrap. Sender and receiver idle at random in phases.
// ----------------------------------------------------------------------------
module tb;
  import dmsef_pkg::*;

  localparam int unsigned DW          = DEF_DIST_WIDTH;
  localparam int unsigned ITEM_TARGET = 850;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned TAIL_CYCLES = 10;
  localparam int unsigned DIST_MAX    = (1 << DW) - 1;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic                  in_valid_i  = 1'b0;
  logic [DW-1:0]         distance_mm_i = '0;
  logic                  out_ready_i = 1'b0;
  logic                  in_ready_o;
  logic                  out_valid_o;
  logic [DW-1:0]         median_mm_o;
  logic [DW-1:0]         held_mm_o;
  logic [DW-1:0]         smooth_mm_o;

  int          fail_count;
  int          words_pending;
  int unsigned cycle_count  = 0;
  int unsigned words_sent   = 0;
  int unsigned cfg_settings = 0;
  int unsigned tx_idle_pct  = 14;
  int unsigned rx_idle_pct  = 47;
  int          walk_mm      = 500;
  int unsigned dropout_left = 0;

  distance_median_skip_exp_filter #(.DIST_WIDTH(DW)) dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_o, .distance_mm_i,
    .out_valid_o, .out_ready_i, .median_mm_o, .held_mm_o, .smooth_mm_o
  );

  dmsef_filter_checker #(.DW(DW)) u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_i(in_ready_o), .distance_mm_i,
    .out_valid_i(out_valid_o), .out_ready_i, .median_mm_i(median_mm_o),
    .held_mm_i(held_mm_o), .smooth_mm_i(smooth_mm_o),
    .fail_count_o(fail_count), .words_pending_o(words_pending)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d words still pending", cycle_count, words_pending);
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic send_word(input logic [DW-1:0] word_mm);
    if (words_sent < ITEM_TARGET / 3) begin
      tx_idle_pct = 14; rx_idle_pct = 47;
    end else if (words_sent < 2 * ITEM_TARGET / 3) begin
      tx_idle_pct = 47; rx_idle_pct = 14;
    end else begin
      tx_idle_pct = 0; rx_idle_pct = 0;
    end
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    distance_mm_i <= word_mm;
    do @(posedge clk_i); while (!in_ready_o);
    words_sent++;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (words_pending != 0) @(negedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // upper data bits on the window write must be ignored
  task automatic set_filter_config(input logic [THR_W-1:0] thr, input logic [WIN_W-1:0] win);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_JUMP_THRESHOLD;
    cfg_wdata_i <= CFG_DATA_W'(thr);
    @(posedge clk_i);
    cfg_idx_i   <= CFG_HOLD_WINDOW;
    cfg_wdata_i <= {CFG_DATA_W'($urandom_range(3)) << WIN_W} | CFG_DATA_W'(win);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
    cfg_settings++;
  endtask

  // drifting target with spikes, dropouts and occasional new targets
  function automatic logic [DW-1:0] next_trace_mm();
    int unsigned roll;
    roll = $urandom_range(99);
    if (dropout_left != 0) begin
      dropout_left--;
      return '0;
    end
    if (roll < 3) dropout_left = $urandom_range(12);
    if (roll < 8) return '0;
    if (roll < 16) return DW'($urandom_range(DIST_MAX));
    if (roll < 20) walk_mm = $urandom_range(DIST_MAX);
    else walk_mm = walk_mm + int'($urandom_range(40)) - 20;
    if (walk_mm < 1) walk_mm = 1;
    if (walk_mm > int'(DIST_MAX)) walk_mm = DIST_MAX;
    return DW'(walk_mm);
  endfunction

  initial begin
    logic [DW-1:0] directed_mm [25];
    int unsigned seg_len;
    directed_mm = '{
      0, 1000, 1000, 1000, 1023, 1023, 1023, 682, 341, 0, 0, 0, 0,
      0, 0, 0, 0, 0, 0, 5, 5, 5, 85, 86, 300
    };
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_mm[i]) send_word(directed_mm[i]);

    // every deviation accepted at once, then settle the held value at 100
    set_filter_config('0, '0);
    repeat (40) send_word(next_trace_mm());
    repeat (3) send_word(DW'(100));

    // held value locked, suspect counter runs past 255 and wraps
    set_filter_config('0, '1);
    repeat (300) send_word(DW'($urandom_range(DIST_MAX, 200)));

    set_filter_config('1, '1);
    repeat (40) send_word(next_trace_mm());

    while (words_sent < ITEM_TARGET) begin
      set_filter_config(
        ($urandom_range(1)) ? THR_W'($urandom_range(200)) : THR_W'($urandom_range(DIST_MAX)),
        ($urandom_range(9) == 0) ? WIN_W'($urandom_range(255)) : WIN_W'($urandom_range(12)));
      seg_len = $urandom_range(60, 30);
      repeat (seg_len) send_word(next_trace_mm());
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("Sent %0d distance words over %0d register settings (reset, extremes, random),",
             words_sent, cfg_settings + 1);
    $display("covering dropouts, spikes, target reappear and suspect counter wrap.");
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
